FILE: hdl/lfu_cache_table_unit_macros.svh
`ifndef LFU_CACHE_TABLE_UNIT_MACROS_SVH
`define LFU_CACHE_TABLE_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define LFU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define LFU_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/lfu_pkg.sv
package lfu_pkg;

    localparam int ENTRIES_DEF    = 16;
    localparam int COUNT_BITS_DEF = 16;
    localparam int CAP_W          = 5;
    localparam int KEY_W          = 32;
    localparam int DATA_W         = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic {
        CMD_GET = 1'b0,
        CMD_PUT = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_UPDATE
    } state_t;

endpackage

FILE: hdl/lfu_cache_table_unit.sv
// done is registered from the decide state at the end of the match scan, high for one cycle
// a new item is taken only in idle: after the rank pass when the table changes (any hit, a put that
// stores), after the scan alone for a get miss or a put at zero capacity
// the entry memories have a single read port, swept once to match and pick a
// victim and once more to rewrite the recency ranks
// reset: asynchronous, all entries invalid, occupancy zero, capacity 16, no clearing pass
module lfu_cache_table_unit #(
    parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
    parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic        [lfu_pkg::CAP_W-1:0]    cfg_wdata,
    input  logic                                start,
    input  logic                                command,
    input  logic signed [lfu_pkg::KEY_W-1:0]    key,
    input  logic signed [lfu_pkg::DATA_W-1:0]   value,
    output logic                                busy,
    output logic                                done,
    output logic                                hit,
    output logic signed [lfu_pkg::DATA_W-1:0]   read_value,
    output logic                                evicted,
    output logic signed [lfu_pkg::KEY_W-1:0]    evicted_key
);

    `include "lfu_cache_table_unit_macros.svh"

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int LIM_W = (CNT_W > lfu_pkg::CAP_W) ? CNT_W : lfu_pkg::CAP_W;
    localparam logic [CNT_W-1:0] ENTRIES_CNT = CNT_W'(ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(ENTRIES - 1);
    localparam logic [LIM_W-1:0] ENTRIES_LIM = LIM_W'(ENTRIES);

    // entry memories
    logic signed [lfu_pkg::KEY_W-1:0]  key_mem   [ENTRIES];
    logic signed [lfu_pkg::DATA_W-1:0] data_mem  [ENTRIES];
    logic        [COUNT_BITS-1:0]      count_mem [ENTRIES];
    logic        [IDX_W-1:0]           rank_mem  [ENTRIES];

    logic signed [lfu_pkg::KEY_W-1:0]  key_rd_reg;
    logic signed [lfu_pkg::DATA_W-1:0] data_rd_reg;
    logic        [COUNT_BITS-1:0]      count_rd_reg;
    logic        [IDX_W-1:0]           rank_rd_reg;

    lfu_pkg::state_t state_reg, state_next;
    lfu_pkg::cmd_t   cmd_reg, cmd_next;

    logic signed [lfu_pkg::KEY_W-1:0]  key_reg, key_next;
    logic signed [lfu_pkg::DATA_W-1:0] val_reg, val_next;
    logic        [lfu_pkg::CAP_W-1:0]  capacity_reg, capacity_next;
    logic        [ENTRIES-1:0]         valid_reg, valid_next;
    logic        [CNT_W-1:0]           occ_reg, occ_next;
    logic        [CNT_W-1:0]           rd_cnt_reg, rd_cnt_next;
    logic                              pipe_vld_reg, pipe_vld_next;
    logic        [IDX_W-1:0]           pipe_idx_reg, pipe_idx_next;

    logic                              found_reg, found_next;
    logic        [IDX_W-1:0]           m_idx_reg, m_idx_next;
    logic        [IDX_W-1:0]           m_rank_reg, m_rank_next;
    logic signed [lfu_pkg::DATA_W-1:0] m_data_reg, m_data_next;
    logic        [COUNT_BITS-1:0]      m_count_reg, m_count_next;

    logic                              vic_found_reg, vic_found_next;
    logic        [IDX_W-1:0]           vic_idx_reg, vic_idx_next;
    logic signed [lfu_pkg::KEY_W-1:0]  vic_key_reg, vic_key_next;
    logic        [IDX_W-1:0]           vic_rank_reg, vic_rank_next;
    logic        [COUNT_BITS-1:0]      vic_count_reg, vic_count_next;

    logic                              free_found_reg, free_found_next;
    logic        [IDX_W-1:0]           free_idx_reg, free_idx_next;

    logic        [IDX_W-1:0]           slot_reg, slot_next;
    logic        [IDX_W-1:0]           thr_reg, thr_next;
    logic                              all_reg, all_next;

    logic                              done_reg, done_next;
    logic                              hit_reg, hit_next;
    logic signed [lfu_pkg::DATA_W-1:0] read_value_reg, read_value_next;
    logic                              evicted_reg, evicted_next;
    logic signed [lfu_pkg::KEY_W-1:0]  evicted_key_reg, evicted_key_next;

    logic                              issue;
    logic        [IDX_W-1:0]           rd_addr;
    logic                              is_put;
    logic        [LIM_W-1:0]           cap_w;
    logic        [LIM_W-1:0]           limit_w;
    logic                              full;
    logic                              evict_now;
    logic        [IDX_W-1:0]           new_slot;

    logic                              entry_we;
    logic                              key_we;
    logic        [IDX_W-1:0]           entry_wr_idx;
    logic signed [lfu_pkg::DATA_W-1:0] data_wdata;
    logic        [COUNT_BITS-1:0]      count_wdata;
    logic                              rank_we;
    logic        [IDX_W-1:0]           rank_wdata;

    assign rd_addr = rd_cnt_reg[IDX_W-1:0];
    assign issue   = (rd_cnt_reg < ENTRIES_CNT);
    assign is_put  = (cmd_reg == lfu_pkg::CMD_PUT);
    assign cap_w   = LIM_W'(capacity_reg);
    assign limit_w = (cap_w < ENTRIES_LIM) ? cap_w : ENTRIES_LIM;
    assign full    = (LIM_W'(occ_reg) >= limit_w);
    assign evict_now = full && vic_found_reg;
    assign new_slot  = (evict_now && !(free_found_reg && (free_idx_reg < vic_idx_reg)))
                     ? vic_idx_reg : free_idx_reg;

    assign busy        = (state_reg != lfu_pkg::ST_IDLE);
    assign done        = done_reg;
    assign hit         = hit_reg;
    assign read_value  = read_value_reg;
    assign evicted     = evicted_reg;
    assign evicted_key = evicted_key_reg;

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[entry_wr_idx] <= key_reg;
        end
        if (entry_we)
        begin
            data_mem[entry_wr_idx]  <= data_wdata;
            count_mem[entry_wr_idx] <= count_wdata;
        end
        if (rank_we)
        begin
            rank_mem[pipe_idx_reg] <= rank_wdata;
        end
        key_rd_reg   <= key_mem[rd_addr];
        data_rd_reg  <= data_mem[rd_addr];
        count_rd_reg <= count_mem[rd_addr];
        rank_rd_reg  <= rank_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lfu_pkg::ST_IDLE;
            capacity_reg   <= lfu_pkg::CAP_RESET;
            valid_reg      <= '0;
            occ_reg        <= '0;
            rd_cnt_reg     <= '0;
            pipe_vld_reg   <= 1'b0;
            found_reg      <= 1'b0;
            vic_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            all_reg        <= 1'b0;
            done_reg       <= 1'b0;
            hit_reg        <= 1'b0;
            evicted_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            capacity_reg   <= capacity_next;
            valid_reg      <= valid_next;
            occ_reg        <= occ_next;
            rd_cnt_reg     <= rd_cnt_next;
            pipe_vld_reg   <= pipe_vld_next;
            found_reg      <= found_next;
            vic_found_reg  <= vic_found_next;
            free_found_reg <= free_found_next;
            all_reg        <= all_next;
            done_reg       <= done_next;
            hit_reg        <= hit_next;
            evicted_reg    <= evicted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        key_reg         <= key_next;
        val_reg         <= val_next;
        pipe_idx_reg    <= pipe_idx_next;
        m_idx_reg       <= m_idx_next;
        m_rank_reg      <= m_rank_next;
        m_data_reg      <= m_data_next;
        m_count_reg     <= m_count_next;
        vic_idx_reg     <= vic_idx_next;
        vic_key_reg     <= vic_key_next;
        vic_rank_reg    <= vic_rank_next;
        vic_count_reg   <= vic_count_next;
        free_idx_reg    <= free_idx_next;
        slot_reg        <= slot_next;
        thr_reg         <= thr_next;
        read_value_reg  <= read_value_next;
        evicted_key_reg <= evicted_key_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        key_next         = key_reg;
        val_next         = val_reg;
        capacity_next    = capacity_reg;
        valid_next       = valid_reg;
        occ_next         = occ_reg;
        rd_cnt_next      = rd_cnt_reg;
        pipe_vld_next    = 1'b0;
        pipe_idx_next    = rd_addr;
        found_next       = found_reg;
        m_idx_next       = m_idx_reg;
        m_rank_next      = m_rank_reg;
        m_data_next      = m_data_reg;
        m_count_next     = m_count_reg;
        vic_found_next   = vic_found_reg;
        vic_idx_next     = vic_idx_reg;
        vic_key_next     = vic_key_reg;
        vic_rank_next    = vic_rank_reg;
        vic_count_next   = vic_count_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        slot_next        = slot_reg;
        thr_next         = thr_reg;
        all_next         = all_reg;
        done_next        = 1'b0;
        hit_next         = hit_reg;
        read_value_next  = read_value_reg;
        evicted_next     = evicted_reg;
        evicted_key_next = evicted_key_reg;
        entry_we         = 1'b0;
        key_we           = 1'b0;
        entry_wr_idx     = new_slot;
        data_wdata       = val_reg;
        count_wdata      = COUNT_BITS'(1);
        rank_we          = 1'b0;
        rank_wdata       = '0;

        if (cfg_we)
        begin
            capacity_next = cfg_wdata;
        end

        unique case (state_reg)
            lfu_pkg::ST_IDLE:
            begin
                rd_cnt_next = '0;
                if (start)
                begin
                    cmd_next        = lfu_pkg::cmd_t'(command);
                    key_next        = key;
                    val_next        = value;
                    found_next      = 1'b0;
                    vic_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = lfu_pkg::ST_SCAN;
                end
            end

            lfu_pkg::ST_SCAN:
            begin
                pipe_vld_next = issue;
                if (issue)
                begin
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                end
                if (pipe_vld_reg)
                begin
                    if (valid_reg[pipe_idx_reg])
                    begin
                        if (!found_reg && (key_rd_reg == key_reg))
                        begin
                            found_next   = 1'b1;
                            m_idx_next   = pipe_idx_reg;
                            m_rank_next  = rank_rd_reg;
                            m_data_next  = data_rd_reg;
                            m_count_next = count_rd_reg;
                        end
                        // lowest count wins, older entry on a tie
                        if (!vic_found_reg || (count_rd_reg < vic_count_reg) ||
                            ((count_rd_reg == vic_count_reg) && (rank_rd_reg > vic_rank_reg)))
                        begin
                            vic_found_next = 1'b1;
                            vic_idx_next   = pipe_idx_reg;
                            vic_key_next   = key_rd_reg;
                            vic_rank_next  = rank_rd_reg;
                            vic_count_next = count_rd_reg;
                        end
                    end
                    else if (!free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = pipe_idx_reg;
                    end
                    if (pipe_idx_reg == LAST_IDX)
                    begin
                        state_next = lfu_pkg::ST_DECIDE;
                    end
                end
            end

            lfu_pkg::ST_DECIDE:
            begin
                done_next        = 1'b1;
                rd_cnt_next      = '0;
                read_value_next  = '0;
                evicted_next     = 1'b0;
                evicted_key_next = '0;
                hit_next         = found_reg;
                priority if (found_reg)
                begin
                    entry_we     = 1'b1;
                    entry_wr_idx = m_idx_reg;
                    data_wdata   = is_put ? val_reg : m_data_reg;
                    count_wdata  = (m_count_reg == '1) ? m_count_reg : m_count_reg + 1'b1;
                    if (!is_put)
                    begin
                        read_value_next = m_data_reg;
                    end
                    slot_next  = m_idx_reg;
                    thr_next   = m_rank_reg;
                    all_next   = 1'b0;
                    state_next = lfu_pkg::ST_UPDATE;
                end
                else if (!is_put || (limit_w == '0))
                begin
                    state_next = lfu_pkg::ST_IDLE;
                end
                else
                begin
                    entry_we     = 1'b1;
                    key_we       = 1'b1;
                    entry_wr_idx = new_slot;
                    slot_next    = new_slot;
                    if (evict_now)
                    begin
                        evicted_next                = 1'b1;
                        evicted_key_next            = vic_key_reg;
                        valid_next[vic_idx_reg]     = 1'b0;
                        thr_next                    = vic_rank_reg;
                        all_next                    = 1'b0;
                    end
                    else
                    begin
                        occ_next = occ_reg + 1'b1;
                        all_next = 1'b1;
                    end
                    valid_next[new_slot] = 1'b1;
                    state_next           = lfu_pkg::ST_UPDATE;
                end
            end

            lfu_pkg::ST_UPDATE:
            begin
                pipe_vld_next = issue;
                if (issue)
                begin
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                end
                if (pipe_vld_reg)
                begin
                    priority if (pipe_idx_reg == slot_reg)
                    begin
                        rank_we    = 1'b1;
                        rank_wdata = '0;
                    end
                    else if (valid_reg[pipe_idx_reg] && (all_reg || (rank_rd_reg < thr_reg)))
                    begin
                        rank_we    = 1'b1;
                        rank_wdata = rank_rd_reg + 1'b1;
                    end
                    if (pipe_idx_reg == LAST_IDX)
                    begin
                        rd_cnt_next = '0;
                        state_next  = lfu_pkg::ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = lfu_pkg::ST_IDLE;
            end
        endcase
    end

    `LFU_ASSERT_IMP(a_occ_tracks_valid, 1'b1, $countones(valid_reg) == int'(occ_reg), "occupancy out of step with valid bits")
    `LFU_ASSERT_IMP(a_evict_only_on_miss, done_reg && evicted_reg, !hit_reg, "eviction reported on a hit")
    `LFU_ASSERT_IMP(a_miss_reads_zero, done_reg && !hit_reg, read_value_reg == '0, "nonzero read value on a miss")
    `LFU_ASSERT_NXT(a_start_enters_scan, start && !busy, state_reg == lfu_pkg::ST_SCAN, "accepted item did not start a scan")

endmodule

FILE: verif/lfu_cache_table_checker.sv
module lfu_cache_table_checker #(
    parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
    parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [lfu_pkg::CAP_W-1:0]     cfg_wdata,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          command,
    input  logic [lfu_pkg::KEY_W-1:0]     key,
    input  logic [lfu_pkg::DATA_W-1:0]    value,
    input  logic                          done,
    input  logic                          hit,
    input  logic [lfu_pkg::DATA_W-1:0]    read_value,
    input  logic                          evicted,
    input  logic [lfu_pkg::KEY_W-1:0]     evicted_key,
    output int                            mismatches,
    output int                            pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                       hit;
        logic [lfu_pkg::DATA_W-1:0] read_value;
        logic                       evicted;
        logic [lfu_pkg::KEY_W-1:0]  evicted_key;
    } cache_reply_t;

    logic                       slot_valid [ENTRIES];
    logic [lfu_pkg::KEY_W-1:0]  slot_key   [ENTRIES];
    logic [lfu_pkg::DATA_W-1:0] slot_data  [ENTRIES];
    logic [COUNT_BITS-1:0]      slot_uses  [ENTRIES];
    int unsigned                slot_age   [ENTRIES];
    int unsigned                fill;
    logic [lfu_pkg::CAP_W-1:0]  capacity_reg;
    cache_reply_t               expected_replies [$];
    cache_reply_t               oldest_reply;

    function automatic cache_reply_t serve_access(lfu_pkg::cmd_t cmd,
                                                  logic [lfu_pkg::KEY_W-1:0] k,
                                                  logic [lfu_pkg::DATA_W-1:0] v);
        cache_reply_t reply;
        int unsigned  limit;
        int unsigned  age;
        int           found;
        int           victim;
        reply = '0;
        limit = (capacity_reg < ENTRIES) ? capacity_reg : ENTRIES;
        found = -1;
        for (int i = ENTRIES - 1; i >= 0; i--)
            if (slot_valid[i] && slot_key[i] == k)
                found = i;

        if (found >= 0)
        begin
            reply.hit = 1'b1;
            if (slot_uses[found] != {COUNT_BITS{1'b1}})
                slot_uses[found] = slot_uses[found] + 1'b1;
            age = slot_age[found];
            for (int i = 0; i < ENTRIES; i++)
                if (slot_valid[i] && i != found && slot_age[i] < age)
                    slot_age[i] = slot_age[i] + 1;
            slot_age[found] = 0;
            if (cmd == lfu_pkg::CMD_PUT)
                slot_data[found] = v;
            else
                reply.read_value = slot_data[found];
            return reply;
        end

        if (cmd == lfu_pkg::CMD_GET || limit == 0)
            return reply;

        // full: drop the least used entry, oldest first on a tie
        if (fill >= limit)
        begin
            victim = -1;
            for (int i = 0; i < ENTRIES; i++)
                if (slot_valid[i] && (victim < 0 || slot_uses[i] < slot_uses[victim] ||
                    (slot_uses[i] == slot_uses[victim] && slot_age[i] > slot_age[victim])))
                    victim = i;
            if (victim >= 0)
            begin
                reply.evicted = 1'b1;
                reply.evicted_key = slot_key[victim];
                age = slot_age[victim];
                slot_valid[victim] = 1'b0;
                for (int i = 0; i < ENTRIES; i++)
                    if (slot_valid[i] && slot_age[i] > age)
                        slot_age[i] = slot_age[i] - 1;
                if (fill > 0)
                    fill--;
            end
        end

        for (int i = 0; i < ENTRIES; i++)
            if (!slot_valid[i])
            begin
                for (int j = 0; j < ENTRIES; j++)
                    if (slot_valid[j])
                        slot_age[j] = slot_age[j] + 1;
                slot_valid[i] = 1'b1;
                slot_key[i] = k;
                slot_data[i] = v;
                slot_uses[i] = COUNT_BITS'(1);
                slot_age[i] = 0;
                fill++;
                break;
            end
        return reply;
    endfunction

    task automatic report_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t %s mismatch: expected %h actual %h", $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
                slot_valid[i] = 1'b0;
            fill = 0;
            capacity_reg = lfu_pkg::CAP_RESET;
            expected_replies.delete();
            pending = 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_replies.size() == 0)
                begin
                    mismatches++;
                    $display("%0t unexpected result: expected none actual %b %h %b %h",
                             $time, hit, read_value, evicted, evicted_key);
                end
                else
                begin
                    oldest_reply = expected_replies.pop_front();
                    report_field("hit", 32'(oldest_reply.hit), 32'(hit));
                    report_field("read_value", oldest_reply.read_value, read_value);
                    report_field("evicted", 32'(oldest_reply.evicted), 32'(evicted));
                    report_field("evicted_key", oldest_reply.evicted_key, evicted_key);
                end
            end
            if (cfg_we)
                capacity_reg = cfg_wdata;
            if (start && !busy)
                expected_replies.push_back(serve_access(lfu_pkg::cmd_t'(command), key, value));
            pending = expected_replies.size();
        end
    end

endmodule

FILE: verif/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SLOTS       = 16;
    localparam int USE_BITS        = 4;
    localparam int PHASES          = 9;
    localparam int ITEMS_PER_PHASE = 215;
    localparam int QUIET_LIMIT     = 3000;

    logic                              clk;
    logic                              rst_n;
    logic                              cfg_we;
    logic [lfu_pkg::CAP_W-1:0]         cfg_wdata;
    logic                              start;
    logic                              command;
    logic signed [lfu_pkg::KEY_W-1:0]  key;
    logic signed [lfu_pkg::DATA_W-1:0] value;
    logic                              busy;
    logic                              done;
    logic                              hit;
    logic signed [lfu_pkg::DATA_W-1:0] read_value;
    logic                              evicted;
    logic signed [lfu_pkg::KEY_W-1:0]  evicted_key;
    int                                mismatches;
    int                                pending;

    // narrow use counts so saturation and the saturated tie break are reached
    lfu_cache_table_unit #(
        .ENTRIES    (NUM_SLOTS),
        .COUNT_BITS (USE_BITS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .start       (start),
        .command     (command),
        .key         (key),
        .value       (value),
        .busy        (busy),
        .done        (done),
        .hit         (hit),
        .read_value  (read_value),
        .evicted     (evicted),
        .evicted_key (evicted_key)
    );

    lfu_cache_table_checker #(
        .ENTRIES    (NUM_SLOTS),
        .COUNT_BITS (USE_BITS)
    ) cache_monitor (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .key         (key),
        .value       (value),
        .done        (done),
        .hit         (hit),
        .read_value  (read_value),
        .evicted     (evicted),
        .evicted_key (evicted_key),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [lfu_pkg::KEY_W-1:0] fresh_key();
        case ($urandom_range(0, 19))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            2:       return 32'h8000_0000;
            3:       return 32'h7fff_ffff;
            default: return $urandom();
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after the item is taken
    task automatic issue(lfu_pkg::cmd_t cmd, logic [lfu_pkg::KEY_W-1:0] k,
                         logic [lfu_pkg::DATA_W-1:0] v);
        start <= 1'b1;
        command <= cmd;
        key <= k;
        value <= v;
        while (busy)
            @(negedge clk);
        @(negedge clk);
    endtask

    task automatic set_capacity(logic [lfu_pkg::CAP_W-1:0] cap);
        start <= 1'b0;
        while (pending != 0 || busy)
            @(negedge clk);
        repeat (NUM_SLOTS + 4) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= cap;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (start && !busy) || done)
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL lfu_cache_table_unit");
        $finish;
    end

    initial
    begin
        logic [lfu_pkg::KEY_W-1:0] key_pool [32];
        logic [lfu_pkg::CAP_W-1:0] phase_caps [PHASES];
        logic [lfu_pkg::KEY_W-1:0] pick;
        int                        pool_size;
        int                        burst_left;
        int                        roll;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = lfu_pkg::CAP_RESET;
        start = 1'b0;
        command = lfu_pkg::CMD_GET;
        key = '0;
        value = '0;
        phase_caps = '{5'd31, 5'd5, 5'd0, 5'd1, 5'd16, 5'd3, 5'd10, 5'd0, 5'd16};
        for (int i = 0; i < 32; i++)
            key_pool[i] = fresh_key();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // field extremes, hits and misses at the reset capacity
        issue(lfu_pkg::CMD_GET, 32'h0000_0000, 32'h0000_0000);
        issue(lfu_pkg::CMD_PUT, 32'h7fff_ffff, 32'h8000_0000);
        issue(lfu_pkg::CMD_PUT, 32'h8000_0000, 32'h7fff_ffff);
        issue(lfu_pkg::CMD_PUT, 32'hffff_ffff, 32'hffff_ffff);
        issue(lfu_pkg::CMD_PUT, 32'h0000_0000, 32'h0000_0000);
        issue(lfu_pkg::CMD_GET, 32'h7fff_ffff, 32'h1234_5678);
        issue(lfu_pkg::CMD_GET, 32'hffff_ffff, 32'h0000_0000);
        issue(lfu_pkg::CMD_PUT, 32'hffff_ffff, 32'h5a5a_5a5a);
        issue(lfu_pkg::CMD_GET, 32'hffff_ffff, 32'hffff_ffff);
        issue(lfu_pkg::CMD_GET, 32'h1234_5678, 32'h0000_0000);
        issue(lfu_pkg::CMD_PUT, 32'h1234_5678, 32'ha5a5_a5a5);

        // capacity below occupancy
        set_capacity(5'd2);
        issue(lfu_pkg::CMD_PUT, 32'h0000_0001, 32'h0000_0001);
        issue(lfu_pkg::CMD_PUT, 32'h0000_0002, 32'hdead_beef);
        issue(lfu_pkg::CMD_GET, 32'h7fff_ffff, 32'h0000_0000);

        // zero capacity keeps held entries
        set_capacity(5'd0);
        issue(lfu_pkg::CMD_PUT, 32'h0000_ffff, 32'h0bad_f00d);
        issue(lfu_pkg::CMD_GET, 32'h0000_ffff, 32'h0000_0000);
        issue(lfu_pkg::CMD_GET, 32'hffff_ffff, 32'h0000_0000);
        issue(lfu_pkg::CMD_PUT, 32'hffff_ffff, 32'h0000_0001);

        set_capacity(5'd31);
        issue(lfu_pkg::CMD_PUT, 32'h0000_ffff, 32'h0bad_f00d);
        issue(lfu_pkg::CMD_GET, 32'h0000_ffff, 32'h0000_0000);
        issue(lfu_pkg::CMD_GET, 32'h0000_0002, 32'h0000_0000);

        burst_left = $urandom_range(1, 30);
        for (int p = 0; p < PHASES; p++)
        begin
            set_capacity(phase_caps[p]);
            pool_size = (phase_caps[p] > NUM_SLOTS ? NUM_SLOTS : phase_caps[p]) +
                        $urandom_range(2, 8);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                roll = $urandom_range(0, 99);
                // skewed pick so some keys run hot and others stay cold
                if (roll < 8)
                    pick = fresh_key();
                else
                    pick = key_pool[$urandom_range(0, $urandom_range(0, pool_size - 1))];
                if (roll >= 97)
                    key_pool[$urandom_range(0, pool_size - 1)] = fresh_key();
                issue(lfu_pkg::cmd_t'($urandom_range(0, 1)), pick, $urandom());
                burst_left--;
                if (burst_left <= 0 && n != ITEMS_PER_PHASE - 1)
                begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 48)) @(negedge clk);
                    burst_left = $urandom_range(1, 30);
                end
            end
        end

        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (2 * NUM_SLOTS + 8) @(negedge clk);
        if (mismatches == 0)
            $display("PASS lfu_cache_table_unit");
        else
            $display("FAIL lfu_cache_table_unit");
        $finish;
    end

endmodule
